@@ src/sfram_pkg.sv @@
// Package for the serial memory slave: command codes, status bits, parser
// phases, result routing types and the register file reset defaults.
// No dependencies.
package sfram_pkg;

  // Transfer operations carried with each item.
  localparam logic [1:0] OP_XFER   = 2'd0;
  localparam logic [1:0] OP_CS_ON  = 2'd1;
  localparam logic [1:0] OP_CS_OFF = 2'd2;

  // Command bytes.
  localparam logic [7:0] CMD_WREN  = 8'h06;
  localparam logic [7:0] CMD_WRDI  = 8'h04;
  localparam logic [7:0] CMD_RDSR  = 8'h05;
  localparam logic [7:0] CMD_WRSR  = 8'h01;
  localparam logic [7:0] CMD_READ  = 8'h03;
  localparam logic [7:0] CMD_WRITE = 8'h02;
  localparam logic [7:0] CMD_RDREG = 8'h13;
  localparam logic [7:0] CMD_WRREG = 8'h12;

  // Status register bits.
  localparam logic [7:0] ST_WEL = 8'(1 << 1);
  localparam logic [7:0] ST_BP0 = 8'(1 << 2);
  localparam logic [7:0] ST_BP1 = 8'(1 << 3);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ADDR_HI,
    PH_ADDR_LO,
    PH_INDEX,
    PH_DATA
  } phase_e;

  // Where the returned byte of an item comes from.
  typedef enum logic [1:0] {
    SRC_BYTE,
    SRC_MEM,
    SRC_REG
  } src_e;

  typedef struct packed {
    src_e       src;
    logic [7:0] data;
    logic       err;
  } res_t;

  // Register file contents after reset.
  function automatic logic [7:0] reg_default(input logic [7:0] idx);
    logic [7:0] val;
    case (idx) inside
      8'd0:                 val = 8'h80;
      8'd13:                val = 8'h01;
      8'd24:                val = 8'h40;
      8'd25, 8'd26, 8'd27:  val = 8'h80;
      8'd28, 8'd29:         val = 8'h81;
      default:              val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

@@ src/sfram_mem.sv @@
// Main byte memory: single port synchronous RAM with registered read data
// and a zeroing sweep after reset. No package dependencies.
module sfram_mem #(
  parameter int unsigned DEPTH = 32768,
  parameter int unsigned AW    = 15
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [7:0]    wdata_i,
  output logic [7:0]    rdata_o,
  output logic          busy_o
);

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata_q;
  logic          clr_busy_q, clr_busy_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= 8'h00;
    end else if (en_i && we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && !we_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clr_busy_q;

endmodule

@@ src/sfram_regs.sv @@
// Companion register file: synchronous RAM with per-entry valid bits so that
// unwritten entries read their reset defaults. Depends on sfram_pkg.
module sfram_regs #(
  parameter int unsigned COUNT = 30,
  parameter int unsigned RW    = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [RW-1:0] idx_i,
  input  logic [7:0]    wdata_i,
  output logic [7:0]    rdata_o
);
  import sfram_pkg::*;

  logic [7:0]       mem [COUNT];
  logic [COUNT-1:0] vld_q;
  logic [7:0]       mem_rd_q;
  logic [7:0]       dflt_q;
  logic             vld_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i && we_i) begin
      vld_q[idx_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem[idx_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && !we_i) begin
      mem_rd_q <= mem[idx_i];
      vld_rd_q <= vld_q[idx_i];
      dflt_q   <= reg_default(8'(idx_i));
    end
  end

  assign rdata_o = vld_rd_q ? mem_rd_q : dflt_q;

endmodule

@@ src/sfram_ctrl.sv @@
// Command parser: phase, command, address pointer, register index, status and
// error latch; issues memory and register file accesses. Depends on sfram_pkg.
module sfram_ctrl #(
  parameter int unsigned MEM_DEPTH = 32768,
  parameter int unsigned REG_COUNT = 30,
  parameter int unsigned AW        = 15,
  parameter int unsigned RW        = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [1:0]          operation_i,
  input  logic [7:0]          tx_byte_i,
  output logic                mem_en_o,
  output logic                mem_we_o,
  output logic [AW-1:0]       mem_addr_o,
  output logic                reg_en_o,
  output logic                reg_we_o,
  output logic [RW-1:0]       reg_idx_o,
  output sfram_pkg::res_t     res_o
);
  import sfram_pkg::*;

  phase_e        phase_q, phase_d;
  logic [7:0]    cmd_q, cmd_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [7:0]    idx_q, idx_d;
  logic [7:0]    status_q, status_d;
  logic          err_q, err_d;

  logic [AW-1:0] hi_tab [256];
  logic [AW:0]   addr_sum;
  logic [AW-1:0] addr_inc;
  logic [8:0]    idx_nxt;
  logic [7:0]    idx_inc;
  logic          idx_ok;
  logic          wel;

  // High address byte times 256, already reduced to the memory size.
  for (genvar g = 0; g < 256; g++) begin : g_hi_tab
    assign hi_tab[g] = AW'((g * 256) % MEM_DEPTH);
  end

  assign addr_sum = {1'b0, addr_q} + (AW + 1)'(tx_byte_i);
  assign addr_inc = (addr_q == AW'(MEM_DEPTH - 1)) ? '0 : addr_q + AW'(1);
  assign idx_nxt  = {1'b0, idx_q} + 9'd1;
  assign idx_inc  = (idx_nxt >= 9'(REG_COUNT)) ? 8'd0 : idx_nxt[7:0];
  assign idx_ok   = {1'b0, idx_q} < 9'(REG_COUNT);
  assign wel      = (status_q & ST_WEL) != 8'h00;

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (fire_i) begin
      if (operation_i == OP_CS_ON || operation_i == OP_CS_OFF) begin
        phase_d = PH_IDLE;
      end else if (operation_i == OP_XFER) begin
        unique case (phase_q)
          PH_ADDR_HI: phase_d = PH_ADDR_LO;
          PH_ADDR_LO: phase_d = PH_DATA;
          PH_INDEX:   phase_d = PH_DATA;
          PH_DATA:    phase_d = PH_DATA;
          default: begin
            unique case (tx_byte_i)
              CMD_RDSR, CMD_WRSR:   phase_d = PH_DATA;
              CMD_READ, CMD_WRITE:  phase_d = PH_ADDR_HI;
              CMD_RDREG, CMD_WRREG: phase_d = PH_INDEX;
              default:              phase_d = PH_IDLE;
            endcase
          end
        endcase
      end
    end
  end

  // Datapath and accesses.
  always_comb begin
    cmd_d     = cmd_q;
    addr_d    = addr_q;
    idx_d     = idx_q;
    status_d  = status_q;
    err_d     = err_q;
    mem_en_o  = 1'b0;
    mem_we_o  = 1'b0;
    reg_en_o  = 1'b0;
    reg_we_o  = 1'b0;
    res_o.src  = SRC_BYTE;
    res_o.data = 8'h00;
    if (fire_i) begin
      if (operation_i == OP_CS_ON || operation_i == OP_CS_OFF) begin
        err_d = 1'b0;
      end else if (operation_i == OP_XFER) begin
        unique case (phase_q)
          PH_ADDR_HI: addr_d = hi_tab[tx_byte_i];
          PH_ADDR_LO: begin
            addr_d = (addr_sum >= (AW + 1)'(MEM_DEPTH)) ?
                     AW'(addr_sum - (AW + 1)'(MEM_DEPTH)) : addr_sum[AW-1:0];
          end
          PH_INDEX: idx_d = tx_byte_i;
          PH_DATA: begin
            unique case (cmd_q)
              CMD_RDSR: res_o.data = status_q;
              CMD_WRSR: begin
                if (wel) begin
                  status_d = (status_q & ~(ST_BP0 | ST_BP1 | ST_WEL)) |
                             (tx_byte_i & (ST_BP0 | ST_BP1));
                end
              end
              CMD_READ: begin
                mem_en_o  = 1'b1;
                res_o.src = SRC_MEM;
                addr_d    = addr_inc;
              end
              CMD_WRITE: begin
                if (wel) begin
                  mem_en_o = 1'b1;
                  mem_we_o = 1'b1;
                  addr_d   = addr_inc;
                end
              end
              CMD_RDREG: begin
                if (idx_ok) begin
                  reg_en_o  = 1'b1;
                  res_o.src = SRC_REG;
                end
                idx_d = idx_inc;
              end
              CMD_WRREG: begin
                if (wel) begin
                  if (idx_ok) begin
                    reg_en_o = 1'b1;
                    reg_we_o = 1'b1;
                  end
                  idx_d = idx_inc;
                end
              end
              default: ;
            endcase
          end
          default: begin
            cmd_d = tx_byte_i;
            unique case (tx_byte_i)
              CMD_WREN: status_d = status_q | ST_WEL;
              CMD_WRDI: status_d = status_q & ~ST_WEL;
              CMD_RDSR, CMD_WRSR, CMD_READ, CMD_WRITE, CMD_RDREG, CMD_WRREG: ;
              default:  err_d = 1'b1;
            endcase
          end
        endcase
      end
    end
    res_o.err = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      cmd_q    <= 8'h00;
      addr_q   <= '0;
      idx_q    <= 8'h00;
      status_q <= 8'h00;
      err_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      cmd_q    <= cmd_d;
      addr_q   <= addr_d;
      idx_q    <= idx_d;
      status_q <= status_d;
      err_q    <= err_d;
    end
  end

  assign mem_addr_o = addr_q;
  assign reg_idx_o  = idx_q[RW-1:0];

`ifndef SYNTHESIS
  a_data_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> cmd_q == CMD_RDSR || cmd_q == CMD_WRSR ||
      cmd_q == CMD_READ || cmd_q == CMD_WRITE || cmd_q == CMD_RDREG ||
      cmd_q == CMD_WRREG)
    else $error("data phase with a command that has no data");
  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, addr_q} < (AW + 1)'(MEM_DEPTH))
    else $error("memory address beyond memory size");
  a_cs_clears_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (operation_i == OP_CS_ON || operation_i == OP_CS_OFF)
      |=> !err_q && phase_q == PH_IDLE)
    else $error("chip select did not clear parser");
`endif

endmodule

@@ src/spi_fram_with_register_file.sv @@
// Top level of the serial memory slave with companion register file.
// Uses sfram_pkg, sfram_ctrl, sfram_mem and sfram_regs.
//
// Usage: each input item is one SPI event: a byte transfer (operation 0,
// with the host byte on tx_byte_i), chip select asserted (1) or released
// (2). Every accepted item yields exactly one result item carrying the
// byte returned to the host (rx_byte_o) and the sticky unknown-command flag
// (cmd_error_o). Both channels use valid/ready handshakes.
// Throughput is one item per cycle while the output is not stalled. A
// result passes the read stage and then the output register: the main
// memory or register file is read at the accepting edge, and the output
// register takes the result from the read stage when it is free or drains.
// After reset the main memory is swept to zero, one byte per cycle, and
// in_ready_o stays low until the sweep is done.
// The register file needs no sweep: valid bits, cleared by reset, make
// unwritten entries read their defaults.
// When the receiver stalls, the output register holds its result, the read
// stage behind it holds one more, and in_ready_o then drops until the
// output is taken.
module spi_fram_with_register_file #(
  parameter int unsigned MEM_DEPTH = 32768,
  parameter int unsigned REG_COUNT = 30
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] tx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] rx_byte_o,
  output logic       cmd_error_o
);
  import sfram_pkg::*;

  localparam int unsigned AW = $clog2(MEM_DEPTH);
  localparam int unsigned RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  logic          fire;
  logic          adv;
  logic          mem_en, mem_we, mem_busy;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_rdata;
  logic          reg_en, reg_we;
  logic [RW-1:0] reg_idx;
  logic [7:0]    reg_rdata;
  res_t          res;

  // Read stage: the result of the item whose memory read is in flight.
  logic          s1_vld_q, s1_vld_d;
  res_t          s1_res_q;
  // Output register.
  logic          out_vld_q, out_vld_d;
  logic [7:0]    rx_q, rx_d;
  logic          err_q;

  // The read stage moves on when the output register is free or drains.
  assign adv        = s1_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !mem_busy && (!s1_vld_q || adv);
  assign fire       = in_valid_i && in_ready_o;

  sfram_ctrl #(
    .MEM_DEPTH(MEM_DEPTH),
    .REG_COUNT(REG_COUNT),
    .AW       (AW),
    .RW       (RW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .operation_i(operation_i),
    .tx_byte_i  (tx_byte_i),
    .mem_en_o   (mem_en),
    .mem_we_o   (mem_we),
    .mem_addr_o (mem_addr),
    .reg_en_o   (reg_en),
    .reg_we_o   (reg_we),
    .reg_idx_o  (reg_idx),
    .res_o      (res)
  );

  sfram_mem #(
    .DEPTH(MEM_DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (mem_en),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(tx_byte_i),
    .rdata_o(mem_rdata),
    .busy_o (mem_busy)
  );

  sfram_regs #(
    .COUNT(REG_COUNT),
    .RW   (RW)
  ) u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (reg_en),
    .we_i   (reg_we),
    .idx_i  (reg_idx),
    .wdata_i(tx_byte_i),
    .rdata_o(reg_rdata)
  );

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (fire) begin
      s1_vld_d = 1'b1;
    end else if (adv) begin
      s1_vld_d = 1'b0;
    end
  end

  // Pick the returned byte from the memory that was read, if any.
  always_comb begin
    unique case (s1_res_q.src)
      SRC_MEM: rx_d = mem_rdata;
      SRC_REG: rx_d = reg_rdata;
      default: rx_d = s1_res_q.data;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      s1_res_q <= res;
    end
    if (adv) begin
      rx_q  <= rx_d;
      err_q <= s1_res_q.err;
    end
  end

  assign out_valid_o = out_vld_q;
  assign rx_byte_o   = rx_q;
  assign cmd_error_o = err_q;

`ifndef SYNTHESIS
  a_out_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(s1_vld_q))
    else $error("result appeared without an item in the read stage");
  a_idle_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_busy |-> !s1_vld_q && !out_vld_q)
    else $error("items in flight during the memory sweep");
  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && !adv |=> s1_vld_q && $stable(s1_res_q))
    else $error("read stage lost its item while stalled");
`endif

endmodule

@@ verif/tb_spi_fram_with_register_file.sv @@
// Self-checking testbench for the serial memory slave with register file.
// Depends on sfram_pkg and the spi_fram_with_register_file RTL, nothing else.
`timescale 1ns / 1ps

module tb_spi_fram_with_register_file;
  import sfram_pkg::*;

  // Sizes of the block under test; the shadow memory in this bench follows
  // MEM_DEPTH, and the register file predictor follows REG_COUNT.
  localparam int unsigned MEM_DEPTH = 32768;
  localparam int unsigned REG_COUNT = 30;

  // Operation code 3 is unused by the protocol; the block must ignore it.
  localparam logic [1:0] OP_IGNORED = 2'd3;
  // A byte that is not a known command.
  localparam logic [7:0] BAD_CMD = 8'hFF;

  localparam int unsigned N_ITEMS     = 1200;
  // The limit covers the memory sweep after reset, the random gaps, the
  // receiver stalls and the long hold-off.
  localparam int unsigned CYCLE_LIMIT = 500000;
  // Length of the single long receiver hold-off.
  localparam int unsigned HOLD_OFF    = 200;
  // Cycles allowed for a stray late result after the last expected one.
  localparam int unsigned DRAIN       = 8;

  // One returned item: the byte shifted out and the sticky error flag.
  typedef struct packed {
    logic [7:0] rx;
    logic       err;
  } reply_t;

  // One row of the directed stimulus. When known is set, the reply is
  // given in the row; otherwise the predictor supplies it.
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] tx;
    logic       known;
    logic [7:0] rx;
    logic       err;
  } stim_row_t;

  localparam int unsigned N_ROWS = 27;
  localparam stim_row_t STIM_ROWS [N_ROWS] = '{
    // Register read across the end of the file: entries 28, 29, then 0.
    '{OP_CS_ON,   8'h00,     1'b1, 8'h00, 1'b0},
    '{OP_XFER,    CMD_RDREG, 1'b1, 8'h00, 1'b0},
    '{OP_XFER,    8'd28,     1'b1, 8'h00, 1'b0},
    '{OP_XFER,    8'h00,     1'b1, 8'h81, 1'b0},
    '{OP_XFER,    8'hFF,     1'b1, 8'h81, 1'b0},
    '{OP_XFER,    8'h00,     1'b1, 8'h80, 1'b0},
    // An index past the file reads as zero.
    '{OP_CS_OFF,  8'hFF,     1'b1, 8'h00, 1'b0},
    '{OP_XFER,    CMD_RDREG, 1'b1, 8'h00, 1'b0},
    '{OP_XFER,    8'hFF,     1'b1, 8'h00, 1'b0},
    '{OP_XFER,    8'h00,     1'b1, 8'h00, 1'b0},
    // Write enable acts on the command byte; the status read shows it.
    '{OP_CS_ON,   8'h00,     1'b1, 8'h00, 1'b0},
    '{OP_XFER,    CMD_WREN,  1'b1, 8'h00, 1'b0},
    '{OP_XFER,    CMD_RDSR,  1'b1, 8'h00, 1'b0},
    '{OP_XFER,    8'h00,     1'b1, ST_WEL, 1'b0},
    // Status write with all ones sets both protect bits and drops WEL.
    '{OP_CS_ON,   8'h00,     1'b0, 8'h00, 1'b0},
    '{OP_XFER,    CMD_WRSR,  1'b0, 8'h00, 1'b0},
    '{OP_XFER,    8'hFF,     1'b1, 8'h00, 1'b0},
    // Unknown command sets the error flag; the unused operation keeps it;
    // releasing the select clears it.
    '{OP_CS_ON,   8'h00,     1'b1, 8'h00, 1'b0},
    '{OP_XFER,    BAD_CMD,   1'b1, 8'h00, 1'b1},
    '{OP_IGNORED, 8'hFF,     1'b1, 8'h00, 1'b1},
    '{OP_CS_OFF,  8'h00,     1'b1, 8'h00, 1'b0},
    // Memory write at the top address, wrapping to zero.
    '{OP_XFER,    CMD_WREN,  1'b0, 8'h00, 1'b0},
    '{OP_XFER,    CMD_WRITE, 1'b0, 8'h00, 1'b0},
    '{OP_XFER,    8'hFF,     1'b0, 8'h00, 1'b0},
    '{OP_XFER,    8'hFF,     1'b0, 8'h00, 1'b0},
    '{OP_XFER,    8'h5A,     1'b0, 8'h00, 1'b0},
    '{OP_XFER,    8'hA5,     1'b0, 8'h00, 1'b0}
  };

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [1:0] operation_i = OP_XFER;
  logic [7:0] tx_byte_i   = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] rx_byte_o;
  logic       cmd_error_o;

  spi_fram_with_register_file #(
    .MEM_DEPTH(MEM_DEPTH),
    .REG_COUNT(REG_COUNT)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .operation_i(operation_i),
    .tx_byte_i  (tx_byte_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .rx_byte_o  (rx_byte_o),
    .cmd_error_o(cmd_error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Shadow copy of the slave's state, advanced once per accepted item.
  phase_e      parse_phase;
  logic [7:0]  active_cmd;
  logic [7:0]  addr_hi;
  int unsigned mem_ptr;
  int unsigned reg_ptr;
  logic [7:0]  status_reg;
  logic        err_flag;
  logic [7:0]  shadow_regs [256];
  logic [7:0]  shadow_mem  [MEM_DEPTH];

  // Replies owed by the block, oldest first.
  reply_t      pending_replies [$];
  int unsigned items_sent    = 0;
  int unsigned burst_left    = 0;
  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;
  bit          hold_off_done = 1'b0;

  // Advances the shadow state by one item and returns the reply it causes.
  function automatic reply_t predict_reply(input logic [1:0] op, input logic [7:0] tx);
    reply_t r;
    logic   wel;
    r.rx = 8'h00;
    wel  = (status_reg & ST_WEL) != 8'h00;
    if (op == OP_CS_ON || op == OP_CS_OFF) begin
      // Either edge of chip select restarts parsing and clears the error.
      parse_phase = PH_IDLE;
      err_flag    = 1'b0;
    end else if (op == OP_XFER) begin
      case (parse_phase)
        PH_ADDR_HI: begin
          addr_hi     = tx;
          parse_phase = PH_ADDR_LO;
        end
        PH_ADDR_LO: begin
          mem_ptr     = {addr_hi, tx} % MEM_DEPTH;
          parse_phase = PH_DATA;
        end
        PH_INDEX: begin
          reg_ptr     = tx;
          parse_phase = PH_DATA;
        end
        PH_DATA: begin
          case (active_cmd)
            CMD_RDSR: r.rx = status_reg;
            CMD_WRSR: begin
              if (wel) begin
                status_reg = (status_reg & ~(ST_BP0 | ST_BP1 | ST_WEL)) |
                             (tx & (ST_BP0 | ST_BP1));
              end
            end
            CMD_READ: begin
              r.rx    = shadow_mem[mem_ptr];
              mem_ptr = (mem_ptr + 1) % MEM_DEPTH;
            end
            CMD_WRITE: begin
              // Without WEL the byte is dropped and the address holds.
              if (wel) begin
                shadow_mem[mem_ptr] = tx;
                mem_ptr = (mem_ptr + 1) % MEM_DEPTH;
              end
            end
            CMD_RDREG: begin
              if (reg_ptr < REG_COUNT) r.rx = shadow_regs[reg_ptr];
              reg_ptr = (reg_ptr + 1 >= REG_COUNT) ? 0 : reg_ptr + 1;
            end
            CMD_WRREG: begin
              if (wel) begin
                if (reg_ptr < REG_COUNT) shadow_regs[reg_ptr] = tx;
                reg_ptr = (reg_ptr + 1 >= REG_COUNT) ? 0 : reg_ptr + 1;
              end
            end
            default: ;
          endcase
        end
        default: begin
          // Idle: the byte is a command.
          active_cmd = tx;
          case (tx)
            CMD_WREN: status_reg = status_reg | ST_WEL;
            CMD_WRDI: status_reg = status_reg & ~ST_WEL;
            CMD_RDSR, CMD_WRSR: parse_phase = PH_DATA;
            CMD_READ, CMD_WRITE: parse_phase = PH_ADDR_HI;
            CMD_RDREG, CMD_WRREG: parse_phase = PH_INDEX;
            default: err_flag = 1'b1;
          endcase
        end
      endcase
    end
    r.err = err_flag;
    return r;
  endfunction

  // Offers one item and waits until it is taken. The sender runs in bursts:
  // when a burst is used up, valid may drop for a random gap first. A long
  // burst now and then gives stretches without any idling.
  task automatic offer_item(input logic [1:0] op, input logic [7:0] tx,
                            input bit known = 1'b0, input reply_t given = '0);
    int unsigned gap;
    reply_t      predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    operation_i <= op;
    tx_byte_i   <= tx;
    do @(posedge clk_i); while (!in_ready_o);
    // The item was taken at this edge; the prediction is made now so the
    // shadow state moves in the same order as the block's.
    predicted = predict_reply(op, tx);
    pending_replies.push_back(known ? given : predicted);
    items_sent++;
  endtask

  // Receiver: out_ready follows a stall rate that changes every segment,
  // from never stalling to stalling almost always. Once, after a few hundred
  // items have gone in, it holds off for a long stretch so the block fills
  // up and has to stall its input while the sender keeps offering.
  initial begin
    int unsigned seg_left;
    int unsigned stall_pct;
    seg_left  = 0;
    stall_pct = 0;
    forever begin
      @(posedge clk_i);
      if (!hold_off_done && items_sent >= 400) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk_i);
        hold_off_done = 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(16, 96);
          case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 25;
            2:       stall_pct = 50;
            default: stall_pct = 90;
          endcase
        end
        seg_left--;
        out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Every reply taken from the block is matched against the oldest one owed.
  always @(posedge clk_i) begin : check_replies
    reply_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected reply: rx_byte %h cmd_error %b", rx_byte_o, cmd_error_o);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (rx_byte_o !== want.rx) begin
          $error("rx_byte mismatch: expected %h, actual %h", want.rx, rx_byte_o);
          mismatches++;
        end
        if (cmd_error_o !== want.err) begin
          $error("cmd_error mismatch: expected %b, actual %b", want.err, cmd_error_o);
          mismatches++;
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL spi_fram_with_register_file");
      $finish;
    end
  end

  initial begin
    logic [7:0]  cmd;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [7:0]  idx;
    int unsigned n_data;
    bit          more;
    bit          cut;

    // Shadow state after reset: memory cleared, register file defaults.
    parse_phase = PH_IDLE;
    active_cmd  = 8'h00;
    addr_hi     = 8'h00;
    mem_ptr     = 0;
    reg_ptr     = 0;
    status_reg  = 8'h00;
    err_flag    = 1'b0;
    foreach (shadow_mem[i]) shadow_mem[i] = 8'h00;
    foreach (shadow_regs[i]) shadow_regs[i] = 8'h00;
    shadow_regs[0]  = 8'h80;
    shadow_regs[13] = 8'h01;
    shadow_regs[24] = 8'h40;
    shadow_regs[25] = 8'h80;
    shadow_regs[26] = 8'h80;
    shadow_regs[27] = 8'h80;
    shadow_regs[28] = 8'h81;
    shadow_regs[29] = 8'h81;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. The block sweeps its memory first; the handshake
    // simply waits for in_ready.
    foreach (STIM_ROWS[i]) begin
      offer_item(STIM_ROWS[i].op, STIM_ROWS[i].tx, STIM_ROWS[i].known,
                 reply_t'{STIM_ROWS[i].rx, STIM_ROWS[i].err});
    end

    // Random part: mostly well-formed selections with random content, so
    // that reads land on addresses and registers written earlier. Some
    // selections are cut short, and stray bytes and the unused operation
    // are mixed in.
    while (items_sent < N_ITEMS) begin
      offer_item(($urandom_range(0, 7) == 0) ? OP_CS_OFF : OP_CS_ON, 8'($urandom));

      // Commands without operands leave the parser idle, so several may
      // follow one another in one selection.
      more = 1'b1;
      while (more) begin
        case ($urandom_range(0, 19))
          0, 1:     cmd = CMD_WREN;
          2:        cmd = CMD_WRDI;
          3, 4:     cmd = CMD_RDSR;
          5:        cmd = CMD_WRSR;
          6, 7, 8:  cmd = CMD_READ;
          9, 10, 11: cmd = CMD_WRITE;
          12, 13:   cmd = CMD_RDREG;
          14, 15, 16: cmd = CMD_WRREG;
          default:  cmd = 8'($urandom);
        endcase
        // Writes are mostly preceded by a write enable so they take effect.
        if ((cmd == CMD_WRITE || cmd == CMD_WRREG || cmd == CMD_WRSR) &&
            $urandom_range(0, 3) != 0) begin
          offer_item(OP_XFER, CMD_WREN);
        end
        offer_item(OP_XFER, cmd);
        more = !(cmd inside {CMD_RDSR, CMD_WRSR, CMD_READ, CMD_WRITE,
                             CMD_RDREG, CMD_WRREG});
        if (more) more = ($urandom_range(0, 2) != 0);
      end

      cut = 1'b0;
      if (cmd == CMD_READ || cmd == CMD_WRITE) begin
        // Mostly a few pages, including the top one where addresses wrap.
        case ($urandom_range(0, 4))
          0:       hi = 8'h00;
          1:       hi = 8'h7F;
          2:       hi = 8'hFF;
          3:       hi = 8'h80;
          default: hi = 8'($urandom);
        endcase
        case ($urandom_range(0, 3))
          0, 1:    lo = 8'($urandom_range(0, 15));
          2:       lo = 8'($urandom_range(8'hF0, 8'hFF));
          default: lo = 8'($urandom);
        endcase
        offer_item(OP_XFER, hi);
        cut = ($urandom_range(0, 19) == 0);
        if (!cut) offer_item(OP_XFER, lo);
      end else if (cmd == CMD_RDREG || cmd == CMD_WRREG) begin
        case ($urandom_range(0, 3))
          0, 1:    idx = 8'($urandom_range(0, REG_COUNT + 1));
          2:       idx = 8'($urandom_range(REG_COUNT - 4, REG_COUNT - 1));
          default: idx = 8'($urandom);
        endcase
        offer_item(OP_XFER, idx);
      end

      if (!cut && (cmd inside {CMD_RDSR, CMD_WRSR, CMD_READ, CMD_WRITE,
                               CMD_RDREG, CMD_WRREG})) begin
        n_data = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 30)
                                             : $urandom_range(1, 8);
        repeat (n_data) begin
          if ($urandom_range(0, 49) == 0) offer_item(OP_IGNORED, 8'($urandom));
          offer_item(OP_XFER, 8'($urandom));
        end
      end

      if ($urandom_range(0, 3) != 0) offer_item(OP_CS_OFF, 8'($urandom));
    end
    in_valid_i <= 1'b0;

    // Wait for every owed reply, then for the DRAIN margin to catch stray ones.
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("PASS spi_fram_with_register_file");
    end else begin
      $display("FAIL spi_fram_with_register_file");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/sfram_pkg.sv
src/sfram_mem.sv
src/sfram_regs.sv
src/sfram_ctrl.sv
src/spi_fram_with_register_file.sv
verif/tb_spi_fram_with_register_file.sv
